// File: rtl/core/tpswd_pkg.sv
// tpswd_pkg: shared types and constants for the triple press safe window detector
// no dependencies; used by triple_press_safe_window_detector
package tpswd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_GAP   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAFE_WINDOW = 1'd1;

  // configuration data width and reset values
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_DATA_W-1:0] PRESS_GAP_RESET   = 16'd500;
  localparam logic [CFG_DATA_W-1:0] SAFE_WINDOW_RESET = 16'd3000;

  // timestamp width
  localparam int unsigned TIME_W = 32;

  // gesture event codes
  localparam logic [1:0] EVT_NONE    = 2'd0;
  localparam logic [1:0] EVT_TRIGGER = 2'd1;
  localparam logic [1:0] EVT_SAFE    = 2'd2;

  // one result item
  typedef struct packed {
    logic [1:0] gesture_event;
    logic       window_open;
    logic [1:0] run_count;
  } result_t;

endpackage

// File: rtl/core/triple_press_safe_window_detector.sv
// triple_press_safe_window_detector: button press gesture detector top level
// depends on tpswd_pkg for codes, reset values and the result type
//
//   channel  direction  handshake              payload
//   in       receive    in_valid / in_stall    press_time_ms
//   out      send       out_valid / out_stall  gesture_event, window_open, run_count
//   cfg      receive    cfg_write              cfg_index, cfg_data
//
// each request is evaluated in the cycle it is taken and its result is
// registered, so one request per cycle is sustained while in_stall is low
// a two-entry result buffer (output register plus skid register) keeps taking
// requests while a result waits; in_stall rises only once both entries hold results
// synchronous active-high rst clears the gesture state, the buffer and the
// configuration registers to their default values
module triple_press_safe_window_detector #(
  parameter int unsigned RUN_TRIGGER_COUNT  = 3,
  parameter int unsigned SAFE_CONFIRM_COUNT = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  // press requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tpswd_pkg::TIME_W-1:0]      press_time_ms,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        gesture_event,
  output logic                              window_open,
  output logic [1:0]                        run_count,
  // configuration writes
  input  logic                              cfg_write,
  input  logic [tpswd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tpswd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned RUN_W = $clog2(RUN_TRIGGER_COUNT + 1);
  localparam int unsigned WIN_W = $clog2(SAFE_CONFIRM_COUNT + 1);
  localparam int unsigned TW    = tpswd_pkg::TIME_W;
  localparam int unsigned CW    = tpswd_pkg::CFG_DATA_W;

  // configuration registers
  logic [CW-1:0] press_gap_ms;
  logic [CW-1:0] safe_window_ms;

  // gesture state
  logic [RUN_W-1:0] run_presses;
  logic [TW-1:0]    last_press_time;
  logic             window_armed;
  logic [WIN_W-1:0] window_presses;
  logic [TW-1:0]    window_deadline;

  logic [RUN_W-1:0] run_presses_next;
  logic [TW-1:0]    last_press_time_next;
  logic             window_armed_next;
  logic [WIN_W-1:0] window_presses_next;
  logic [TW-1:0]    window_deadline_next;
  logic [1:0]       event_code;

  // result buffer
  tpswd_pkg::result_t out_result;
  tpswd_pkg::result_t skid_result;
  tpswd_pkg::result_t new_result;
  logic               skid_valid;

  logic          in_take;
  logic          out_take;
  logic [TW-1:0] diff_last;
  logic [TW-1:0] diff_deadline;
  logic          gap_over;
  logic          expired;
  logic [RUN_W-1:0] run_base;
  logic [RUN_W-1:0] run_inc;
  logic [WIN_W-1:0] win_inc;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      press_gap_ms   <= tpswd_pkg::PRESS_GAP_RESET;
      safe_window_ms <= tpswd_pkg::SAFE_WINDOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tpswd_pkg::REG_PRESS_GAP:   press_gap_ms   <= cfg_data;
        tpswd_pkg::REG_SAFE_WINDOW: safe_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // wrap-aware time differences read as signed values
  assign diff_last     = press_time_ms - last_press_time;
  assign diff_deadline = press_time_ms - window_deadline;
  assign gap_over = !diff_last[TW-1] && (diff_last[TW-2:0] > (TW-1)'(press_gap_ms));
  assign expired  = !diff_deadline[TW-1] && (diff_deadline != '0);

  assign run_base = gap_over ? '0 : run_presses;
  assign run_inc  = run_base + RUN_W'(1);
  assign win_inc  = window_presses + WIN_W'(1);

  // gesture next state
  always_comb begin
    run_presses_next     = run_presses;
    last_press_time_next = press_time_ms;
    window_armed_next    = window_armed;
    window_presses_next  = window_presses;
    window_deadline_next = window_deadline;
    event_code           = tpswd_pkg::EVT_NONE;
    if (window_armed) begin
      if (expired) begin
        // late press closes the window and starts a new run
        window_armed_next   = 1'b0;
        window_presses_next = '0;
        run_presses_next    = RUN_W'(1);
      end else if (win_inc >= WIN_W'(SAFE_CONFIRM_COUNT)) begin
        // confirmation count reached inside the window
        window_armed_next   = 1'b0;
        window_presses_next = '0;
        run_presses_next    = '0;
        event_code          = tpswd_pkg::EVT_SAFE;
      end else begin
        window_presses_next = win_inc;
      end
    end else begin
      if (run_inc >= RUN_W'(RUN_TRIGGER_COUNT)) begin
        // run complete: arm the safe window
        run_presses_next     = '0;
        window_armed_next    = 1'b1;
        window_presses_next  = '0;
        window_deadline_next = press_time_ms + TW'(safe_window_ms);
        event_code           = tpswd_pkg::EVT_TRIGGER;
      end else begin
        run_presses_next = run_inc;
      end
    end
  end

  assign new_result.gesture_event = event_code;
  assign new_result.window_open   = window_armed_next;
  assign new_result.run_count     = run_presses_next[1:0];

  // gesture state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_presses     <= '0;
      last_press_time <= '0;
      window_armed    <= 1'b0;
      window_presses  <= '0;
      window_deadline <= '0;
    end else if (in_take) begin
      run_presses     <= run_presses_next;
      last_press_time <= last_press_time_next;
      window_armed    <= window_armed_next;
      window_presses  <= window_presses_next;
      window_deadline <= window_deadline_next;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_take;
        end
      end else if (in_take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_result <= skid_result;
      end else if (in_take) begin
        out_result <= new_result;
      end
    end else if (in_take) begin
      skid_result <= new_result;
    end
  end

  assign gesture_event = out_result.gesture_event;
  assign window_open   = out_result.window_open;
  assign run_count     = out_result.run_count;

endmodule
